// File: rtl/core/cwp_pkg.sv
// Shared constants, register codes and elaboration-time table functions for the CW propagator.
`timescale 1ns / 1ps

package cwp_pkg;

  // Constants in Q.60, angles in radians; GAIN_SEED is in Q.32.
  localparam logic [63:0]        ONE_Q60        = 64'h1000000000000000;
  localparam logic [63:0]        THREE_Q60      = 64'h3000000000000000;
  localparam logic signed [63:0] PI_Q60         = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] TWO_PI_Q60     = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] HALF_PI_Q60    = 64'sh1921FB54442D1847;
  localparam logic [63:0]        QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
  localparam logic [63:0]        GAIN_SEED      = 64'h9B74EDA8;

  // Halves of two pi in Q.60 and the reciprocal floor(2^94 / two pi) for the phase reduction.
  localparam logic [31:0]  TWO_PI_HI      = 32'h6487ED51;
  localparam logic [31:0]  TWO_PI_LO      = 32'h10B4611A;
  localparam logic [127:0] TWO_PI_RECIP_W = (128'd1 << 94) / {64'd0, TWO_PI_Q60};
  localparam logic [31:0]  TWO_PI_RECIP   = TWO_PI_RECIP_W[31:0];

  // Saturation limits of a 48-bit signed result field.
  localparam logic [47:0] SAT_MAX = 48'h7FFFFFFFFFFF;
  localparam logic [47:0] SAT_MIN = 48'h800000000000;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    CFG_AXIS   = 4'd0,
    CFG_MOTION = 4'd1,
    CFG_K0     = 4'd2,
    CFG_K1     = 4'd3,
    CFG_K2     = 4'd4,
    CFG_K3     = 4'd5,
    CFG_K4     = 4'd6,
    CFG_K5     = 4'd7
  } cfg_idx_t;

  // Q.60 product, truncated.
  function automatic logic [63:0] fmul60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[123:60];
  endfunction

  // Arctangent of 2^-idx in Q.60 from the alternating series.
  function automatic logic [63:0] atan_entry(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned d;
    acc = '0;
    if (idx == 0) begin
      acc = QUARTER_PI_Q60;
    end else begin
      for (int unsigned k = 0; idx * (2 * k + 1) <= 60; k++) begin
        d = 2 * k + 1;
        term = (64'd1 << (60 - idx * d)) / 64'(d);
        acc = k[0] ? acc - term : acc + term;
      end
    end
    return acc;
  endfunction

  // Reciprocal of the CORDIC gain by four Newton steps.
  function automatic logic [63:0] cordic_gain(input int unsigned stages);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] py2;
    p = ONE_Q60;
    y = GAIN_SEED << 28;
    for (int unsigned i = 0; i < stages && i < 64; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int unsigned j = 0; j < 4; j++) begin
      py2 = fmul60(p, fmul60(y, y));
      y = fmul60(y, THREE_Q60 - py2) >> 1;
    end
    return y;
  endfunction

endpackage

// File: rtl/core/cwp_mul.sv
// Pipelined signed-by-unsigned multiplier, one digit of the unsigned operand per stage.
`timescale 1ns / 1ps

module cwp_mul #(
  parameter int AW = 49,
  parameter int BW = 48,
  parameter int DW = 16,
  parameter int ND = 3,
  parameter int TW = 1,
  localparam int PW = AW + 1 + ND * DW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  input  logic                 neg,
  input  logic [TW-1:0]        tag_i,
  output logic signed [PW-1:0] p,
  output logic [TW-1:0]        tag_o
);

  localparam int BX = ND * DW;

  logic signed [AW:0]   a_r   [0:ND];
  logic [BX-1:0]        b_r   [0:ND];
  logic signed [PW-1:0] acc_r [0:ND];
  logic [TW-1:0]        tag_r [0:ND];

  // Entry stage: apply the sign to the wide operand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
      a_r[0]   <= neg ? -((AW + 1)'(a)) : (AW + 1)'(a);
      b_r[0]   <= BX'(b);
      acc_r[0] <= '0;
    end
  end

  // One partial product and one accumulate per stage.
  for (genvar j = 0; j < ND; j++) begin : g_dig
    logic signed [AW+DW+1:0] pp;
    assign pp = a_r[j] * $signed({1'b0, b_r[j][j*DW +: DW]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j+1] <= '0;
      end else if (en) begin
        tag_r[j+1] <= tag_r[j];
        a_r[j+1]   <= a_r[j];
        b_r[j+1]   <= b_r[j];
        acc_r[j+1] <= acc_r[j] + (PW'(pp) <<< (j * DW));
      end
    end
  end

  assign p     = acc_r[ND];
  assign tag_o = tag_r[ND];

endmodule

// File: rtl/core/cwp_cordic.sv
// Rotation-mode CORDIC pipeline, one micro-rotation per stage, Q.60 angles.
`timescale 1ns / 1ps

module cwp_cordic import cwp_pkg::*; #(
  parameter int STAGES = 32,
  parameter int TW     = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [63:0] z_i,
  input  logic [TW-1:0]      tag_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic [TW-1:0]      tag_o
);

  localparam logic signed [63:0] GAIN = signed'(cordic_gain(STAGES));

  logic signed [63:0] x_r   [0:STAGES-1];
  logic signed [63:0] y_r   [0:STAGES-1];
  logic signed [63:0] z_r   [0:STAGES-1];
  logic [TW-1:0]      tag_r [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [63:0] ANG = signed'(atan_entry(i));
    logic signed [63:0] x_in;
    logic signed [63:0] y_in;
    logic signed [63:0] z_in;
    logic [TW-1:0]      t_in;
    logic signed [63:0] dx;
    logic signed [63:0] dy;

    if (i == 0) begin : g_first
      assign x_in = GAIN;
      assign y_in = '0;
      assign z_in = z_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign t_in = tag_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    // Rotate toward zero residual angle.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i] <= '0;
      end else if (en) begin
        tag_r[i] <= t_in;
        if (!z_in[63]) begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - ANG;
        end else begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + ANG;
        end
      end
    end
  end

  assign x_o   = x_r[STAGES-1];
  assign y_o   = y_r[STAGES-1];
  assign tag_o = tag_r[STAGES-1];

endmodule

// File: rtl/core/cw_relative_orbit_propagator_top.sv
// Top level of the Clohessy-Wiltshire relative orbit propagator pipeline.
//
//  Channel | Handshake          | Word
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | in_time_query
//  out     | out_valid/out_stall| out_pos_*, out_vel_*, out_saturated
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low; words pass through the
// four-stage reciprocal phase reduction, the CORDIC stages and the digit multipliers.
// Reset clears the configuration to its defaults and empties the pipeline.
// Stalling a valid result freezes the whole pipeline; in_stall rises in the same cycle.
// Configuration writes are always taken and also reach words already in the pipeline.
`timescale 1ns / 1ps

module cw_relative_orbit_propagator_top import cwp_pkg::*; #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [47:0] in_time_query,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pos_radial,
  output logic signed [47:0] out_pos_along,
  output logic signed [47:0] out_pos_cross,
  output logic signed [47:0] out_vel_radial,
  output logic signed [47:0] out_vel_along,
  output logic signed [47:0] out_vel_cross,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int PH_W  = 88;
  localparam int IW    = 144;

  // Configuration registers.
  logic [31:0] a_r;
  logic [39:0] n_r;
  logic [47:0] k_r [0:5];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 32'd7000000;
      n_r <= '0;
      for (int i = 0; i < 6; i++) k_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AXIS:   a_r    <= cfg_data[31:0];
        CFG_MOTION: n_r    <= cfg_data[39:0];
        CFG_K0:     k_r[0] <= cfg_data;
        CFG_K1:     k_r[1] <= cfg_data;
        CFG_K2:     k_r[2] <= cfg_data;
        CFG_K3:     k_r[3] <= cfg_data;
        CFG_K4:     k_r[4] <= cfg_data;
        CFG_K5:     k_r[5] <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Magnitude and sign of each constant.
  logic        kneg [0:5];
  logic [47:0] kmag [0:5];
  for (genvar i = 0; i < 6; i++) begin : g_kmag
    assign kneg[i] = k_r[i][47];
    assign kmag[i] = k_r[i][47] ? -k_r[i] : k_r[i];
  end

  // Velocity scale a*n, refreshed every cycle from the registers.
  logic [51:0] an_lo_r;
  logic [51:0] an_hi_r;
  logic [71:0] an_r;

  always_ff @(posedge clk) begin
    an_lo_r <= a_r * n_r[19:0];
    an_hi_r <= a_r * n_r[39:20];
    an_r    <= 72'(an_lo_r) + (72'(an_hi_r) << 20);
  end

  // Global advance: the pipeline moves unless a finished word is held.
  logic out_valid_r;
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Input capture: time magnitude and sign.
  logic        v0_r;
  logic        tneg0_r;
  logic [47:0] tmag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r    <= in_valid;
      tneg0_r <= in_time_query[47];
      tmag0_r <= in_time_query[47] ? 48'(-in_time_query) : in_time_query;
    end
  end

  // Phase |t| * n in Q.56.
  logic signed [97:0] ph_p;
  logic [1:0]         ph_tag;

  cwp_mul #(.AW(49), .BW(48), .DW(16), .ND(3), .TW(2)) u_mul_ph (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .a     (signed'({1'b0, tmag0_r})),
    .b     ({8'd0, n_r}),
    .neg   (1'b0),
    .tag_i ({v0_r, tneg0_r}),
    .p     (ph_p),
    .tag_o (ph_tag)
  );

  // Phase reduction, first step: the quotient estimate by two pi from the top
  // 32 bits of the Q.56 phase. The estimate is the true quotient or one less.
  logic [63:0]     rq_prod_r;
  logic [63:0]     rq_nlo_r;
  logic [PH_W-1:0] rq_ph_r;
  logic            rq_neg_r;
  logic            rq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_v_r <= 1'b0;
    end else if (en) begin
      rq_v_r    <= ph_tag[1];
      rq_neg_r  <= ph_tag[0];
      rq_ph_r   <= ph_p[PH_W-1:0];
      rq_nlo_r  <= {ph_p[59:0], 4'd0};
      rq_prod_r <= ph_p[PH_W-1:PH_W-32] * TWO_PI_RECIP;
    end
  end

  // Second step: the low 64 bits of quotient times two pi, in two halves.
  logic [29:0]     rq_q;
  logic [61:0]     rm_lo_r;
  logic [31:0]     rm_hi_r;
  logic [63:0]     rm_nlo_r;
  logic [PH_W-1:0] rm_ph_r;
  logic            rm_neg_r;
  logic            rm_v_r;

  assign rq_q = rq_prod_r[63:34];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_v_r <= 1'b0;
    end else if (en) begin
      rm_v_r   <= rq_v_r;
      rm_neg_r <= rq_neg_r;
      rm_ph_r  <= rq_ph_r;
      rm_nlo_r <= rq_nlo_r;
      rm_lo_r  <= 62'(rq_q) * 62'(TWO_PI_LO);
      rm_hi_r  <= 32'(rq_q) * TWO_PI_HI;
    end
  end

  // Third step: partial remainder, below twice two pi so 64 bits hold it.
  logic [63:0]     rr_r;
  logic [PH_W-1:0] rr_ph_r;
  logic            rr_neg_r;
  logic            rr_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_v_r <= 1'b0;
    end else if (en) begin
      rr_v_r   <= rm_v_r;
      rr_neg_r <= rm_neg_r;
      rr_ph_r  <= rm_ph_r;
      rr_r     <= rm_nlo_r - (64'(rm_lo_r) + {rm_hi_r, 32'd0});
    end
  end

  // Last step: one conditional subtraction gives the exact remainder.
  logic [62:0]     red_rem_r;
  logic [PH_W-1:0] red_ph_r;
  logic            red_neg_r;
  logic            red_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r <= 1'b0;
    end else if (en) begin
      red_v_r   <= rr_v_r;
      red_neg_r <= rr_neg_r;
      red_ph_r  <= rr_ph_r;
      red_rem_r <= (rr_r >= TWO_PI_Q60) ? 63'(rr_r - TWO_PI_Q60) : rr_r[62:0];
    end
  end

  // Fold the reduced phase into [-pi/2, pi/2].
  logic signed [63:0] rs0;
  logic signed [63:0] fz_nxt;
  logic               fflip_nxt;

  always_comb begin
    rs0 = signed'({1'b0, red_rem_r});
    if (rs0 > PI_Q60) rs0 = rs0 - TWO_PI_Q60;
    fz_nxt    = rs0;
    fflip_nxt = 1'b0;
    if (rs0 > HALF_PI_Q60) begin
      fz_nxt    = rs0 - PI_Q60;
      fflip_nxt = 1'b1;
    end else if (rs0 < -HALF_PI_Q60) begin
      fz_nxt    = rs0 + PI_Q60;
      fflip_nxt = 1'b1;
    end
  end

  logic signed [63:0] fz_r;
  logic               fflip_r;
  logic               ftneg_r;
  logic [PH_W-1:0]    fph_r;
  logic               fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r    <= red_v_r;
      fz_r    <= fz_nxt;
      fflip_r <= fflip_nxt;
      ftneg_r <= red_neg_r;
      fph_r   <= red_ph_r;
    end
  end

  // Sine and cosine.
  logic signed [63:0] cx;
  logic signed [63:0] cy;
  logic [PH_W+2:0]    ctag;

  cwp_cordic #(.STAGES(CORDIC_STAGES), .TW(PH_W + 3)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .z_i   (fz_r),
    .tag_i ({fv_r, ftneg_r, fflip_r, fph_r}),
    .x_o   (cx),
    .y_o   (cy),
    .tag_o (ctag)
  );

  // Undo the fold and apply the sign of t to the sine.
  logic signed [63:0] s_r;
  logic signed [63:0] c_r;
  logic               scneg_r;
  logic [PH_W-1:0]    scph_r;
  logic               scv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scv_r <= 1'b0;
    end else if (en) begin
      scv_r   <= ctag[PH_W+2];
      scneg_r <= ctag[PH_W+1];
      scph_r  <= ctag[PH_W-1:0];
      c_r     <= ctag[PH_W] ? -cx : cx;
      s_r     <= (ctag[PH_W] ^ ctag[PH_W+1]) ? -cy : cy;
    end
  end

  // Constant-by-trig products, and K0 by the phase for the drift term.
  logic signed [137:0] pk [0:7];
  logic signed [137:0] p0;
  logic                p0_v;

  for (genvar j = 0; j < 8; j++) begin : g_kmul
    localparam int KI = (j < 4) ? 1 + j / 2 : 4 + (j - 4) / 2;
    logic signed [88:0] trig;
    if (j % 2 == 0) begin : g_sin
      assign trig = 89'(s_r);
    end else begin : g_cos
      assign trig = 89'(c_r);
    end

    cwp_mul #(.AW(89), .BW(48), .DW(16), .ND(3), .TW(1)) u_mul_k (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a     (trig),
      .b     (kmag[KI]),
      .neg   (kneg[KI]),
      .tag_i (1'b0),
      .p     (pk[j]),
      .tag_o ()
    );
  end

  cwp_mul #(.AW(89), .BW(48), .DW(16), .ND(3), .TW(1)) u_mul_drift (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .a     (signed'({1'b0, scph_r})),
    .b     (kmag[0]),
    .neg   (kneg[0] ^ scneg_r),
    .tag_i (scv_r),
    .p     (p0),
    .tag_o (p0_v)
  );

  // Sign-extended terms in Q.90; the drift term e0 is in Q.86.
  logic signed [IW-1:0] e0, e1s, e1c, e2s, e2c, e4s, e4c, e5s, e5c, k0w, k3w;
  assign e0  = IW'(p0);
  assign e1s = IW'(pk[0]);
  assign e1c = IW'(pk[1]);
  assign e2s = IW'(pk[2]);
  assign e2c = IW'(pk[3]);
  assign e4s = IW'(pk[4]);
  assign e4c = IW'(pk[5]);
  assign e5s = IW'(pk[6]);
  assign e5c = IW'(pk[7]);
  assign k0w = IW'($signed(k_r[0])) <<< 60;
  assign k3w = IW'($signed(k_r[3])) <<< 60;

  // First adder level; coefficients are in halves.
  logic signed [IW-1:0] xa_r, xb_r, ya_r, yb_r, z_r, vx_r, vya_r, vyb_r, vz_r;
  logic                 sav_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sav_r <= 1'b0;
    end else if (en) begin
      sav_r <= p0_v;
      xa_r  <= (k0w <<< 1) + (e1s <<< 1);
      xb_r  <= e2c <<< 1;
      ya_r  <= (e1c <<< 2) - (e0 <<< 5);
      yb_r  <= (k3w <<< 1) - (e2s <<< 2) - (e0 <<< 4);
      z_r   <= (e4s <<< 1) + (e5c <<< 1);
      vx_r  <= (e1c <<< 1) - (e2s <<< 1);
      vya_r <= -(k0w <<< 1) - k0w;
      vyb_r <= -(e1s <<< 2) - (e2c <<< 2);
      vz_r  <= (e4c <<< 1) - (e5s <<< 1);
    end
  end

  // Second adder level: unscaled sums for the six components.
  logic signed [IW-1:0] sb_r [0:5];
  logic                 sbv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbv_r <= 1'b0;
    end else if (en) begin
      sbv_r    <= sav_r;
      sb_r[0]  <= xa_r + xb_r;
      sb_r[1]  <= ya_r + yb_r;
      sb_r[2]  <= z_r;
      sb_r[3]  <= vx_r;
      sb_r[4]  <= vya_r + vyb_r;
      sb_r[5]  <= vz_r;
    end
  end

  // Scale by a for positions and by a*n for velocities.
  logic signed [216:0] sm [0:5];
  logic [5:0]          sm_v;

  for (genvar j = 0; j < 6; j++) begin : g_scale
    logic [71:0] scl;
    if (j < 3) begin : g_pos
      assign scl = {40'd0, a_r};
    end else begin : g_vel
      assign scl = an_r;
    end

    cwp_mul #(.AW(IW), .BW(72), .DW(8), .ND(9), .TW(1)) u_mul_s (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a     (sb_r[j]),
      .b     (scl),
      .neg   (1'b0),
      .tag_i (sbv_r),
      .p     (sm[j]),
      .tag_o (sm_v[j])
    );
  end

  // Round half up, then saturate to 48 bits.
  logic signed [217:0] rnd_r [0:5];
  logic                r1v_r;
  logic [47:0]         res_w [0:5];
  logic [5:0]          sat_w;

  for (genvar j = 0; j < 6; j++) begin : g_rnd
    localparam int SH = (j < 3) ? 91 : 115;
    logic [217-SH-47:0] hi;

    always_ff @(posedge clk) begin
      if (en) rnd_r[j] <= 218'(sm[j]) + $signed(218'(1) << (SH - 1));
    end

    assign hi       = rnd_r[j][217:SH+47];
    assign sat_w[j] = !((&hi) || !(|hi));
    assign res_w[j] = sat_w[j] ? (rnd_r[j][217] ? SAT_MIN : SAT_MAX) : rnd_r[j][SH+47:SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1v_r <= 1'b0;
    end else if (en) begin
      r1v_r <= sm_v[0];
    end
  end

  // Output register.
  logic [47:0] out_r [0:5];
  logic        sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r1v_r;
      sat_r       <= |sat_w;
      for (int i = 0; i < 6; i++) out_r[i] <= res_w[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_radial = out_r[0];
  assign out_pos_along  = out_r[1];
  assign out_pos_cross  = out_r[2];
  assign out_vel_radial = out_r[3];
  assign out_vel_along  = out_r[4];
  assign out_vel_cross  = out_r[5];
  assign out_saturated  = sat_r;

endmodule

// File: rtl/core/cwp_checker.sv
// Port-level checks for the CW propagator, bound to the top level.
`timescale 1ns / 1ps

module cwp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [47:0] in_time_query,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_pos_radial,
  input logic signed [47:0] out_pos_along,
  input logic signed [47:0] out_pos_cross,
  input logic signed [47:0] out_vel_radial,
  input logic signed [47:0] out_vel_along,
  input logic signed [47:0] out_vel_cross,
  input logic               out_saturated,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [3:0]         cfg_index,
  input logic [47:0]        cfg_data
);

  // A held result word stays valid, its radial position and cross-track velocity unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_radial) && $stable(out_vel_cross))
    else $error("held result word changed");

  // The input is only back-pressured by a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A clamped word carries a limit value in some field.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_pos_radial == 48'sh7FFFFFFFFFFF || out_pos_radial == 48'sh800000000000 ||
      out_pos_along  == 48'sh7FFFFFFFFFFF || out_pos_along  == 48'sh800000000000 ||
      out_pos_cross  == 48'sh7FFFFFFFFFFF || out_pos_cross  == 48'sh800000000000 ||
      out_vel_radial == 48'sh7FFFFFFFFFFF || out_vel_radial == 48'sh800000000000 ||
      out_vel_along  == 48'sh7FFFFFFFFFFF || out_vel_along  == 48'sh800000000000 ||
      out_vel_cross  == 48'sh7FFFFFFFFFFF || out_vel_cross  == 48'sh800000000000)
    else $error("saturation flag without a clamped field");

  // The pipeline comes out of reset empty.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cw_relative_orbit_propagator_top cwp_checker u_cwp_checker (.*);
